// ===== src/sls_pkg.sv =====
// Shared constants, codes and types of the stair light sequencer.
package sls_pkg;

  localparam int LEDS_PER_STEP = 6;
  localparam int STEP_COUNT    = 3;
  localparam int LED_TOTAL     = LEDS_PER_STEP * STEP_COUNT;

  localparam int OUT_W    = 36;
  localparam int OUT_LEDS = (LED_TOTAL < OUT_W / 2) ? LED_TOTAL : OUT_W / 2;

  localparam int FP_W = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
  localparam int SP_W = $clog2(STEP_COUNT + 1);

  localparam int MODE_W     = 3;
  localparam int ELAPSED_W  = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int FILL_IV_W  = 8;
  localparam int WIPE_IV_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FILL_UP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FILL_DOWN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WIPE_UP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WIPE_DOWN = 3'd4;

  localparam logic [1:0] COL_OFF   = 2'd0;
  localparam logic [1:0] COL_WHITE = 2'd1;
  localparam logic [1:0] COL_GLOW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_IV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIPE_IV = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd10000;
  localparam logic [FILL_IV_W-1:0] FILL_IV_RST = 8'd5;
  localparam logic [WIPE_IV_W-1:0] WIPE_IV_RST = 16'd1000;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [FILL_IV_W-1:0] fill_interval;
    logic [WIPE_IV_W-1:0] wipe_interval;
  } sls_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]              mode;
    logic [ELAPSED_W-1:0]           elapsed;
    logic [FP_W-1:0]                fill_ptr;
    logic [SP_W-1:0]                step_ptr;
    logic [FILL_IV_W-1:0]           fill_phase;
    logic [WIPE_IV_W-1:0]           wipe_phase;
    logic [LED_TOTAL-1:0][1:0]      leds;
  } sls_state_t;

  typedef struct packed {
    logic [OUT_W-1:0]  led_colours;
    logic [MODE_W-1:0] mode_now;
    logic              idle_glow;
  } sls_result_t;

endpackage

// ===== src/sls_in_if.sv =====
// Input channel: one tick with both sensor levels.
interface sls_in_if;
  logic valid;
  logic ready;
  logic bottom_sensor;
  logic top_sensor;

  modport source (output valid, output bottom_sensor, output top_sensor, input ready);
  modport sink   (input valid, input bottom_sensor, input top_sensor, output ready);
endinterface

// ===== src/sls_out_if.sv =====
// Result channel: LED colours, mode and glow flag for one tick.
interface sls_out_if;
  logic                              valid;
  logic                              ready;
  logic [sls_pkg::OUT_W-1:0]         led_colours;
  logic [sls_pkg::MODE_W-1:0]        mode_now;
  logic                              idle_glow;

  modport source (output valid, output led_colours, output mode_now, output idle_glow,
                  input ready);
  modport sink   (input valid, input led_colours, input mode_now, input idle_glow,
                  output ready);
endinterface

// ===== src/sls_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface sls_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sls_pkg::CFG_IDX_W-1:0]   index;
  logic [sls_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/sls_tick.sv =====
// Next-state and result logic for one tick of the sequencer.
module sls_tick (
  input  sls_pkg::sls_state_t  st_i,
  input  logic                 bottom_i,
  input  logic                 top_i,
  input  sls_pkg::sls_cfg_t    cfg_i,
  output sls_pkg::sls_state_t  st_o,
  output sls_pkg::sls_result_t res_o
);

  localparam logic [sls_pkg::FP_W-1:0] LAST_LED = sls_pkg::FP_W'(sls_pkg::LED_TOTAL - 1);

  logic [sls_pkg::MODE_W-1:0]      mode;
  logic [sls_pkg::ELAPSED_W-1:0]   elapsed;
  logic [sls_pkg::FILL_IV_W:0]     fill_next;
  logic [sls_pkg::FILL_IV_W-1:0]   fill_lim;
  logic [sls_pkg::WIPE_IV_W:0]     wipe_next;
  logic [sls_pkg::WIPE_IV_W-1:0]   wipe_lim;
  logic                            fill_fire;
  logic                            wipe_fire;
  logic                            glow;
  logic [sls_pkg::FP_W-1:0]        fpc;
  logic [sls_pkg::LED_TOTAL-1:0][1:0] leds;

  always_comb begin
    st_o = st_i;

    // saturating elapsed count
    elapsed = (st_i.elapsed == '1) ? st_i.elapsed : st_i.elapsed + 16'd1;
    mode    = st_i.mode;

    if (bottom_i && mode != sls_pkg::MODE_FILL_DOWN) begin
      mode    = sls_pkg::MODE_FILL_UP;
      elapsed = '0;
    end
    if (top_i && mode != sls_pkg::MODE_FILL_UP) begin
      mode    = sls_pkg::MODE_FILL_DOWN;
      elapsed = '0;
    end
    if ((mode == sls_pkg::MODE_FILL_UP || mode == sls_pkg::MODE_FILL_DOWN) &&
        elapsed > cfg_i.timeout_ticks) begin
      mode = mode + 3'd2;
    end

    leds = st_i.leds;
    glow = !bottom_i && !top_i && mode == sls_pkg::MODE_IDLE;
    if (glow) begin
      elapsed       = '0;
      st_o.fill_ptr = '0;
      st_o.step_ptr = '0;
      for (int i = 0; i < sls_pkg::LED_TOTAL; i++) begin
        if (i % sls_pkg::LEDS_PER_STEP == 0 ||
            i % sls_pkg::LEDS_PER_STEP == sls_pkg::LEDS_PER_STEP - 1) begin
          leds[i] = sls_pkg::COL_GLOW;
        end
      end
    end

    // free-running phases; an interval of zero behaves as one
    fill_lim  = (cfg_i.fill_interval == '0) ? 8'd1 : cfg_i.fill_interval;
    fill_next = {1'b0, st_i.fill_phase} + 9'd1;
    fill_fire = fill_next >= {1'b0, fill_lim};
    st_o.fill_phase = fill_fire ? '0 : fill_next[sls_pkg::FILL_IV_W-1:0];

    wipe_lim  = (cfg_i.wipe_interval == '0) ? 16'd1 : cfg_i.wipe_interval;
    wipe_next = {1'b0, st_i.wipe_phase} + 17'd1;
    wipe_fire = wipe_next >= {1'b0, wipe_lim};
    st_o.wipe_phase = wipe_fire ? '0 : wipe_next[sls_pkg::WIPE_IV_W-1:0];

    fpc = (int'(st_i.fill_ptr) < sls_pkg::LED_TOTAL) ? st_i.fill_ptr : LAST_LED;

    if (mode == sls_pkg::MODE_FILL_UP || mode == sls_pkg::MODE_FILL_DOWN) begin
      st_o.step_ptr = '0;
      if (fill_fire) begin
        for (int i = 0; i < sls_pkg::LED_TOTAL; i++) begin
          if (mode == sls_pkg::MODE_FILL_UP) begin
            if (i <= int'(fpc)) leds[i] = sls_pkg::COL_WHITE;
          end else begin
            if (i >= sls_pkg::LED_TOTAL - 1 - int'(fpc)) leds[i] = sls_pkg::COL_WHITE;
          end
        end
        st_o.fill_ptr = (fpc < LAST_LED) ? fpc + sls_pkg::FP_W'(1) : fpc;
      end
    end else if (mode == sls_pkg::MODE_WIPE_UP || mode == sls_pkg::MODE_WIPE_DOWN) begin
      if (wipe_fire) begin
        if (int'(st_i.step_ptr) < sls_pkg::STEP_COUNT) begin
          for (int i = 0; i < sls_pkg::LED_TOTAL; i++) begin
            if (mode == sls_pkg::MODE_WIPE_UP) begin
              if (i / sls_pkg::LEDS_PER_STEP <= int'(st_i.step_ptr))
                leds[i] = sls_pkg::COL_OFF;
            end else begin
              if (i / sls_pkg::LEDS_PER_STEP >= sls_pkg::STEP_COUNT - 1 - int'(st_i.step_ptr))
                leds[i] = sls_pkg::COL_OFF;
            end
          end
          st_o.step_ptr = st_i.step_ptr + sls_pkg::SP_W'(1);
        end else begin
          mode = sls_pkg::MODE_IDLE;
        end
      end
    end

    st_o.mode    = mode;
    st_o.elapsed = elapsed;
    st_o.leds    = leds;

    res_o = '0;
    for (int i = 0; i < sls_pkg::OUT_LEDS; i++) begin
      res_o.led_colours[2*i +: 2] = leds[i];
    end
    res_o.mode_now  = mode;
    res_o.idle_glow = glow;
  end

endmodule

// ===== src/stair_light_sequencer.sv =====
// Top level of the staircase LED strip sequencer.
//
// Usage: send one item on in_ch for every millisecond tick, carrying the
// bottom and top motion sensor levels. Each tick yields exactly one result
// on out_ch: the colour code of every LED (two bits each, LED 0 lowest),
// the mode after the tick and whether the idle glow was applied.
// cfg_ch writes timeout_ticks (index 0), fill_interval (index 1) and
// wipe_interval (index 2); it is always ready and other indexes are dropped.
// Write configuration only while no tick is in flight.
//
// The input register loads at the transfer edge and the single-pass tick
// logic fills the result register from it once that register is free or
// its result is taken, and the result transfers from there.
// Throughput is one tick per cycle while the receiver takes results; the
// state update sits between those two registers.
// Reset clears the mode to idle, all counters and phases to zero, all LEDs
// to off and the registers to 10000, 5 and 1000.
// When the receiver stalls, the result register holds and the input
// register still takes one more tick; after that in_ch.ready drops.
module stair_light_sequencer (
  input logic      clk,
  input logic      rst_n,
  sls_in_if.sink   in_ch,
  sls_out_if.source out_ch,
  sls_cfg_if.sink  cfg_ch
);

  logic                 in_valid_r;
  logic                 in_bot_r;
  logic                 in_top_r;
  logic                 out_valid_r;
  logic                 advance;
  sls_pkg::sls_state_t  st_r;
  sls_pkg::sls_state_t  st_nxt;
  sls_pkg::sls_cfg_t    cfg_r;
  sls_pkg::sls_result_t out_r;
  sls_pkg::sls_result_t out_nxt;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  sls_tick u_tick (
    .st_i     (st_r),
    .bottom_i (in_bot_r),
    .top_i    (in_top_r),
    .cfg_i    (cfg_r),
    .st_o     (st_nxt),
    .res_o    (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      st_r                <= '0;
      cfg_r.timeout_ticks <= sls_pkg::TIMEOUT_RST;
      cfg_r.fill_interval <= sls_pkg::FILL_IV_RST;
      cfg_r.wipe_interval <= sls_pkg::WIPE_IV_RST;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          sls_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_ch.data;
          sls_pkg::CFG_FILL_IV: cfg_r.fill_interval <= cfg_ch.data[sls_pkg::FILL_IV_W-1:0];
          sls_pkg::CFG_WIPE_IV: cfg_r.wipe_interval <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_bot_r <= in_ch.bottom_sensor;
      in_top_r <= in_ch.top_sensor;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.led_colours = out_r.led_colours;
  assign out_ch.mode_now    = out_r.mode_now;
  assign out_ch.idle_glow   = out_r.idle_glow;

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("tick advanced but no result became valid");

  a_state_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("sequencer state changed without a tick");

  a_quiet_idle_glows: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_bot_r && !in_top_r && st_r.mode == sls_pkg::MODE_IDLE
    |=> out_r.idle_glow && out_r.mode_now == sls_pkg::MODE_IDLE)
    else $error("quiet tick in idle did not apply glow");

endmodule
